>>> rtl/ffha_pkg.sv
package ffha_pkg;

    localparam int MAX_BLOCKS   = 64;
    localparam int HEADER_BYTES = 16;
    localparam int IDX_W        = $clog2(MAX_BLOCKS);
    localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);
    localparam int SCAN_W       = $clog2(MAX_BLOCKS + 2);

    localparam logic       MODE_ALLOC = 1'b0;
    localparam logic       MODE_FREE  = 1'b1;
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ZERO    = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_BAD     = 2'd3;

    localparam logic [1:0] CFG_BASE   = 2'd0;
    localparam logic [1:0] CFG_LIMIT  = 2'd1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN
    } state_t;

    typedef struct packed {
        logic             mode;
        logic [31:0]      size;
        logic [31:0]      hdr;
        logic [CNT_W-1:0] count;
    } req_t;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
        logic [31:0]      base;
        logic [31:0]      bytes;
    } probe_t;

    typedef struct packed {
        logic             en;
        logic             mark_only;
        logic [IDX_W-1:0] idx;
        logic [31:0]      base;
        logic [31:0]      bytes;
        logic             is_free;
    } wr_t;

endpackage

>>> rtl/ffha_cell.sv
module ffha_cell
    import ffha_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [IDX_W-1:0] cell_idx,
    input  req_t             req,
    input  wr_t              wr,
    input  probe_t           probe_in,
    output probe_t           probe_out
);

    logic [31:0] base_reg;
    logic [31:0] bytes_reg;
    logic        free_reg;
    probe_t      probe_reg;
    probe_t      probe_next;
    logic        live;
    logic        hit;

    always_comb begin
        live = ({1'b0, cell_idx} < req.count);
        if (req.mode == MODE_ALLOC) begin
            hit = live && free_reg && (bytes_reg >= req.size);
        end else begin
            hit = live && (base_reg == req.hdr);
        end
        probe_next = probe_in;
        if (!probe_in.found && hit) begin
            probe_next.found = 1'b1;
            probe_next.idx   = cell_idx;
            probe_next.base  = base_reg;
            probe_next.bytes = bytes_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            probe_reg.found <= 1'b0;
        end else begin
            probe_reg.found <= probe_next.found;
        end
        probe_reg.idx   <= probe_next.idx;
        probe_reg.base  <= probe_next.base;
        probe_reg.bytes <= probe_next.bytes;
        if (wr.en && wr.idx == cell_idx) begin
            free_reg <= wr.is_free;
            if (!wr.mark_only) begin
                base_reg  <= wr.base;
                bytes_reg <= wr.bytes;
            end
        end
    end

    assign probe_out = probe_reg;

endmodule

>>> rtl/first_fit_heap_allocator_unit.sv
// First-fit heap allocator. The block table lives in a chain of MAX_BLOCKS
// cells, and each item sends one probe down the chain, one cell per cycle.
// The unit accepts the next item only once it is idle again, after the
// result of the last one is loaded into the output register. A result still
// waiting in the output register holds the finished scan until it is taken.
// An allocate item reuses the first free block that is large enough,
// otherwise it appends a block at the heap top, or reports a zero size or a
// full heap; a free item pops the tail block or marks the block free, or
// reports a bad address.
module first_fit_heap_allocator_unit
    import ffha_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,  // request_size, payload_address
    input  logic        s_tuser,  // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,  // result_address, status, zero fill
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);

    state_t            state_reg, state_next;
    logic [SCAN_W-1:0] cnt_reg, cnt_next;
    logic              mode_reg;
    logic [31:0]       size_reg;
    logic [31:0]       addr_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [31:0]       top_reg, top_next;
    logic [31:0]       limit_reg;
    logic              mvalid_reg, mvalid_next;
    logic [31:0]       maddr_reg, maddr_next;
    logic [1:0]        mstat_reg, mstat_next;
    logic              load;
    req_t              req;
    wr_t               wr;
    probe_t            chain [MAX_BLOCKS+1];
    logic [33:0]       end_sum;
    logic [32:0]       tail_end;
    logic [31:0]       hdr;

    assign hdr = addr_reg - 32'(HEADER_BYTES);
    assign req = '{mode: mode_reg, size: size_reg, hdr: hdr, count: count_reg};
    assign chain[0] = '{found: 1'b0, idx: '0, base: '0, bytes: '0};

    genvar g;
    generate
        for (g = 0; g < MAX_BLOCKS; g++) begin : g_cell
            ffha_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .cell_idx (IDX_W'(g)),
                .req      (req),
                .wr       (wr),
                .probe_in (chain[g]),
                .probe_out(chain[g+1])
            );
        end
    endgenerate

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {6'd0, mstat_reg, maddr_reg};

    assign end_sum  = {2'b00, top_reg} + 34'(HEADER_BYTES) + {2'b00, size_reg};
    assign tail_end = {1'b0, addr_reg} + {1'b0, chain[MAX_BLOCKS].bytes};

    always_comb begin
        probe_t p;
        p           = chain[MAX_BLOCKS];
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        count_next  = count_reg;
        top_next    = top_reg;
        mvalid_next = mvalid_reg;
        maddr_next  = maddr_reg;
        mstat_next  = mstat_reg;
        load        = 1'b0;
        wr          = '{en: 1'b0, mark_only: 1'b1, idx: '0, base: top_reg,
                        bytes: size_reg, is_free: 1'b0};
        if (mvalid_reg && m_tready) begin
            mvalid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    load       = 1'b1;
                    cnt_next   = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (cnt_reg != SCAN_W'(MAX_BLOCKS)) begin
                    cnt_next = cnt_reg + 1'b1;
                end else if (!mvalid_reg || m_tready) begin
                    mvalid_next = 1'b1;
                    maddr_next  = '0;
                    state_next  = S_IDLE;
                    if (mode_reg == MODE_ALLOC) begin
                        if (size_reg == '0) begin
                            mstat_next = ST_ZERO;
                        end else if (p.found) begin
                            wr.en      = 1'b1;
                            wr.idx     = p.idx;
                            maddr_next = p.base + 32'(HEADER_BYTES);
                            mstat_next = ST_OK;
                        end else if (count_reg == CNT_W'(MAX_BLOCKS)
                                     || end_sum > {2'b00, limit_reg}) begin
                            mstat_next = ST_FULL;
                        end else begin
                            wr.en        = 1'b1;
                            wr.mark_only = 1'b0;
                            wr.idx       = count_reg[IDX_W-1:0];
                            count_next   = count_reg + 1'b1;
                            top_next     = end_sum[31:0];
                            maddr_next   = top_reg + 32'(HEADER_BYTES);
                            mstat_next   = ST_OK;
                        end
                    end else begin
                        if (count_reg == '0 || addr_reg < 32'(HEADER_BYTES) || !p.found) begin
                            mstat_next = ST_BAD;
                        end else begin
                            mstat_next = ST_OK;
                            if ({1'b0, p.idx} == count_reg - 1'b1
                                && tail_end == {1'b0, top_reg}) begin
                                count_next = count_reg - 1'b1;
                                top_next   = p.base;
                            end else begin
                                wr.en      = 1'b1;
                                wr.idx     = p.idx;
                                wr.is_free = 1'b1;
                            end
                        end
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        if (cfg_we && cfg_index == CFG_BASE && count_reg == '0) begin
            top_next = cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            count_reg  <= '0;
            top_reg    <= '0;
            limit_reg  <= '1;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            count_reg  <= count_next;
            top_reg    <= top_next;
            mvalid_reg <= mvalid_next;
            if (cfg_we && cfg_index == CFG_LIMIT) begin
                limit_reg <= cfg_wdata;
            end
        end
        maddr_reg <= maddr_next;
        mstat_reg <= mstat_next;
        if (load) begin
            mode_reg <= s_tuser;
            size_reg <= s_tdata[31:0];
            addr_reg <= s_tdata[63:32];
        end
    end

endmodule

>>> tb/first_fit_heap_allocator_unit_test.sv
`timescale 1ns / 1ps

module first_fit_heap_allocator_unit_test;
    import ffha_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_wdata = '0;

    first_fit_heap_allocator_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    typedef struct packed {
        logic [31:0] addr;
        logic [1:0]  status;
    } grant_t;

    logic [31:0] heap_limit_q;
    logic [31:0] tbl_base [MAX_BLOCKS];
    logic [31:0] tbl_bytes [MAX_BLOCKS];
    logic        tbl_free [MAX_BLOCKS];
    int          tbl_count;
    logic [31:0] top_q;

    grant_t      pending_grants[$];
    logic [31:0] live_addrs[$];
    int          mismatches = 0;
    int          received = 0;
    bit          hold_off = 1'b0;
    int          burst_left = 0;

    function automatic grant_t predict_grant(logic mode, logic [31:0] size, logic [31:0] paddr);
        grant_t g;
        logic [32:0] endp;
        logic [31:0] hdr;
        int i;
        g.addr = '0;
        if (mode == MODE_ALLOC) begin
            if (size == 0) begin
                g.status = ST_ZERO;
                return g;
            end
            for (i = 0; i < tbl_count; i++) begin
                if (tbl_free[i] && tbl_bytes[i] >= size) begin
                    tbl_free[i] = 1'b0;
                    g.addr = tbl_base[i] + HEADER_BYTES;
                    g.status = ST_OK;
                    return g;
                end
            end
            endp = {1'b0, top_q} + HEADER_BYTES + {1'b0, size};
            if (tbl_count >= MAX_BLOCKS || endp > {1'b0, heap_limit_q}) begin
                g.status = ST_FULL;
                return g;
            end
            tbl_base[tbl_count] = top_q;
            tbl_bytes[tbl_count] = size;
            tbl_free[tbl_count] = 1'b0;
            tbl_count++;
            g.addr = top_q + HEADER_BYTES;
            g.status = ST_OK;
            top_q = endp[31:0];
            return g;
        end
        g.status = ST_BAD;
        if (tbl_count == 0 || paddr < HEADER_BYTES) return g;
        hdr = paddr - HEADER_BYTES;
        if (hdr < tbl_base[0] || hdr > tbl_base[tbl_count-1]) return g;
        for (i = 0; i < tbl_count; i++)
            if (tbl_base[i] == hdr) break;
        if (i >= tbl_count) return g;
        endp = {1'b0, paddr} + {1'b0, tbl_bytes[i]};
        if (i == tbl_count - 1 && endp == {1'b0, top_q}) begin
            tbl_count--;
            top_q = tbl_base[i];
        end else begin
            tbl_free[i] = 1'b1;
        end
        g.status = ST_OK;
        return g;
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_BASE) begin
            if (tbl_count == 0) top_q = val;
        end else if (idx == CFG_LIMIT) begin
            heap_limit_q = val;
        end
    endtask

    task automatic send_item(logic mode, logic [31:0] size, logic [31:0] paddr);
        grant_t g;
        if (burst_left == 0) begin
            repeat ($urandom_range(0, 6)) @(posedge aclk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        @(posedge aclk);
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= {paddr, size};
        do @(posedge aclk); while (!s_tready);
        g = predict_grant(mode, size, paddr);
        if (mode == MODE_ALLOC && g.status == ST_OK) live_addrs.push_back(g.addr);
        pending_grants.push_back(g);
        s_tvalid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_grants.size() != 0) @(posedge aclk);
        repeat (MAX_BLOCKS + 8) @(posedge aclk);
    endtask

    task automatic reset_shadow();
        heap_limit_q = '1;
        tbl_count = 0;
        top_q = '0;
    endtask

    function automatic logic [31:0] pick_free_addr();
        int k;
        if (live_addrs.size() == 0 || $urandom_range(0, 9) == 0) return $urandom;
        k = $urandom_range(0, live_addrs.size() - 1);
        if ($urandom_range(0, 7) == 0) return live_addrs[k] + $urandom_range(1, 20);
        return live_addrs[k];
    endfunction

    task automatic test_directed();
        send_item(MODE_FREE, 0, 32'h100);
        send_item(MODE_ALLOC, 0, 0);
        send_item(MODE_ALLOC, 32'd8, 0);
        send_item(MODE_ALLOC, 32'd24, 0);
        send_item(MODE_ALLOC, 32'd4, 0);
        send_item(MODE_FREE, 0, 32'd4);
        send_item(MODE_FREE, 0, 32'd15);
        send_item(MODE_FREE, 0, 32'd17);
        send_item(MODE_FREE, 0, 32'hFFFF_FFFF);
        send_item(MODE_FREE, 0, 32'd16);
        send_item(MODE_FREE, 0, 32'd16);
        send_item(MODE_ALLOC, 32'd8, 0);
        send_item(MODE_FREE, 0, 32'd40);
        send_item(MODE_ALLOC, 32'd30, 0);
        send_item(MODE_FREE, 0, 32'd96);
        send_item(MODE_FREE, 0, 32'd96);
        send_item(MODE_ALLOC, 32'hFFFF_FFFF, 0);
        send_item(MODE_ALLOC, 32'hFFFF_FFA0, 0);
        drain();
    endtask

    task automatic test_limits();
        write_reg(CFG_LIMIT, 32'hFFFF_FFFF);
        write_reg(CFG_BASE, 32'h1000);
        write_reg(2'd3, 32'h5555);
        write_reg(CFG_LIMIT, 32'h1000 + 16 * 40);
        repeat (40) send_item(MODE_ALLOC, 32'd1, 0);
        repeat (30) send_item(MODE_ALLOC, 32'd2, 0);
        send_item(MODE_ALLOC, 32'd1, 0);
        drain();
        write_reg(CFG_LIMIT, 32'hFFFF_FFFF);
        write_reg(CFG_BASE, 32'hFFFF_FF00);
        repeat (70) send_item(MODE_ALLOC, $urandom_range(1, 3), 0);
        while (live_addrs.size() != 0) send_item(MODE_FREE, 0, live_addrs.pop_back());
        drain();
    endtask

    task automatic test_random(int n, logic [31:0] base, logic [31:0] lim);
        int i;
        logic [31:0] sz;
        write_reg(CFG_BASE, base);
        write_reg(CFG_LIMIT, lim);
        for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 1) == 0) begin
                case ($urandom_range(0, 9))
                    0: sz = 0;
                    1: sz = $urandom;
                    default: sz = $urandom_range(1, 300);
                endcase
                send_item(MODE_ALLOC, sz, $urandom);
            end else begin
                send_item(MODE_FREE, $urandom, pick_free_addr());
            end
        end
        drain();
        while (live_addrs.size() != 0) void'(live_addrs.pop_front());
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            begin
                repeat (400) @(posedge aclk);
                hold_off = 1'b0;
            end
            repeat (8) send_item(MODE_ALLOC, $urandom_range(1, 50), 0);
        join
        drain();
    endtask

    initial begin
        reset_shadow();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_limits();
        test_backpressure();
        test_random(700, 32'h0, 32'hFFFF_FFFF);
        test_random(450, $urandom, 32'hFFFF_FFFF);
        test_random(450, 32'h2000, 32'h2000 + $urandom_range(200, 4000));
        drain();
        if (mismatches == 0 && pending_grants.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    always @(posedge aclk) begin
        if (!aresetn || hold_off)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(0, 3) != 0) || (received % 64 < 16);
    end

    always @(posedge aclk) begin
        grant_t want;
        if (aresetn && m_tvalid && m_tready) begin
            received++;
            if (pending_grants.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected item: %h", m_tdata);
            end else begin
                want = pending_grants.pop_front();
                if (m_tdata[31:0] !== want.addr || m_tdata[33:32] !== want.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected addr %h status %0d, got addr %h status %0d",
                                 want.addr, want.status, m_tdata[31:0], m_tdata[33:32]);
                end
            end
        end
    end

    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule

>>> files.f
rtl/ffha_pkg.sv
rtl/ffha_cell.sv
rtl/first_fit_heap_allocator_unit.sv
tb/first_fit_heap_allocator_unit_test.sv
